[rtl/ecgrr_pkg.sv]
package ecgrr_pkg;

    typedef logic [1:0] cls_t;

    localparam cls_t CLS_N = 2'd0;
    localparam cls_t CLS_V = 2'd1;
    localparam cls_t CLS_A = 2'd2;

    localparam logic [3:0] LVL_NORMAL    = 4'd0;
    localparam logic [3:0] LVL_APC       = 4'd1;
    localparam logic [3:0] LVL_PVC       = 4'd2;
    localparam logic [3:0] LVL_PAUSE     = 4'd3;
    localparam logic [3:0] LVL_COUPLET   = 4'd4;
    localparam logic [3:0] LVL_TRIGEMINY = 4'd5;
    localparam logic [3:0] LVL_BIGEMINY  = 4'd6;
    localparam logic [3:0] LVL_ARUN      = 4'd7;
    localparam logic [3:0] LVL_VRUN      = 4'd8;

    localparam int POS_BITS_DEF = 32;
    localparam int POS_IN_W     = 32;
    localparam int WIDTH_W      = 10;
    localparam int PAUSE_W      = 12;
    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 8;
    localparam int PADDR_W      = 3;

    localparam int REG_WIDE_QRS = 0;
    localparam int REG_PAUSE    = 1;

    localparam logic [WIDTH_W-1:0] WIDE_QRS_RST = 10'd27;
    localparam logic [PAUSE_W-1:0] PAUSE_RST    = 12'd300;

    // premature: 1000*rr <= 855*avg + 1060; window: 2*rr < 3*avg, 10*rr > 7*avg
    localparam int RR_SCALE   = 1000;
    localparam int AVG_SCALE  = 855;
    localparam int PREM_BIAS  = 1060;
    localparam int WIN_HI_RR  = 2;
    localparam int WIN_HI_AVG = 3;
    localparam int WIN_LO_RR  = 10;
    localparam int WIN_LO_AVG = 7;

    typedef struct packed {
        logic all_valid;
        logic premature;
        logic in_win;
        logic pause;
    } ivl_status_t;

endpackage

[rtl/ecgrr_interval.sv]
module ecgrr_interval #(
    parameter int POS_BITS = ecgrr_pkg::POS_BITS_DEF
) (
    input  logic [POS_BITS-1:0]            pos_new,
    input  logic [POS_BITS-1:0]            pos_old [5],
    input  logic [POS_BITS-1:0]            avg,
    input  logic [ecgrr_pkg::PAUSE_W-1:0]  pause_thr,
    output logic [POS_BITS-1:0]            rr [5],
    output ecgrr_pkg::ivl_status_t         status
);
    import ecgrr_pkg::*;

    localparam int PW = POS_BITS + 11;
    localparam int HW = POS_BITS + 2;
    localparam int LW = POS_BITS + 4;

    logic [POS_BITS-1:0] cur;
    logic [PW-1:0]       prem_lhs;
    logic [PW-1:0]       prem_rhs;
    logic [HW-1:0]       hi_lhs;
    logic [HW-1:0]       hi_rhs;
    logic [LW-1:0]       lo_lhs;
    logic [LW-1:0]       lo_rhs;
    logic                any_zero;

    always_comb
    begin
        any_zero = (pos_new == '0);
        for (int i = 0; i < 5; i++)
        begin
            any_zero = any_zero | (pos_old[i] == '0);
        end
        for (int i = 0; i < 4; i++)
        begin
            rr[i] = pos_old[i+1] - pos_old[i];
        end
        rr[4] = pos_new - pos_old[4];
    end

    assign cur      = rr[4];
    assign prem_lhs = PW'(cur) * PW'(RR_SCALE);
    assign prem_rhs = PW'(avg) * PW'(AVG_SCALE) + PW'(PREM_BIAS);
    assign hi_lhs   = HW'(cur) * HW'(WIN_HI_RR);
    assign hi_rhs   = HW'(avg) * HW'(WIN_HI_AVG);
    assign lo_lhs   = LW'(avg) * LW'(WIN_LO_AVG);
    assign lo_rhs   = LW'(cur) * LW'(WIN_LO_RR);

    assign status.all_valid = ~any_zero;
    assign status.premature = (prem_lhs <= prem_rhs);
    assign status.in_win    = (hi_lhs < hi_rhs) && (lo_lhs < lo_rhs);
    assign status.pause     = (cur >= POS_BITS'(pause_thr));

endmodule

[rtl/ecgrr_rhythm.sv]
module ecgrr_rhythm (
    input  ecgrr_pkg::cls_t t,
    input  ecgrr_pkg::cls_t hist [5],
    input  logic            pause,
    output logic [3:0]      flag
);
    import ecgrr_pkg::*;

    cls_t t1, t2, t3, t4, t5;

    assign t1 = hist[0];
    assign t2 = hist[1];
    assign t3 = hist[2];
    assign t4 = hist[3];
    assign t5 = hist[4];

    always_comb
    begin
        if (t2 == CLS_V && t1 == CLS_V && t == CLS_V)
            flag = LVL_VRUN;
        else if (t2 == CLS_A && t1 == CLS_A && t == CLS_A)
            flag = LVL_ARUN;
        else if (t3 == CLS_N && t2 == CLS_V && t1 == CLS_N && t == CLS_V)
            flag = LVL_BIGEMINY;
        else if (t5 == CLS_N && t4 == CLS_N && t3 == CLS_V && t2 == CLS_N &&
                 t1 == CLS_N && t == CLS_V)
            flag = LVL_TRIGEMINY;
        else if (t5 == CLS_V && t4 == CLS_V && t3 == CLS_N && t2 == CLS_V &&
                 t1 == CLS_V && t == CLS_N)
            flag = LVL_TRIGEMINY;
        else if (t1 == CLS_V && t == CLS_V)
            flag = LVL_COUPLET;
        else if (pause)
            flag = LVL_PAUSE;
        else if (t == CLS_V)
            flag = LVL_PVC;
        else if (t == CLS_A)
            flag = LVL_APC;
        else
            flag = LVL_NORMAL;
    end

endmodule

[rtl/ecg_rr_beat_rhythm_classifier_top.sv]
// RR-interval beat and rhythm classifier.
// Input stream: one request per detected QRS. tdata carries the beat position
// (low 32 bits) and the QRS width (next 10 bits); tuser is the restart flag,
// which clears the history before the beat is handled.
// Output stream: one request per input request, in order. tdata carries the
// beat class (bits 1:0) and the sticky rhythm level (bits 5:2); tuser is the
// classified flag, low while fewer than six nonzero positions are held.
// The APB port holds the wide-QRS threshold (0x0) and the pause threshold (0x4);
// write them only while the block is idle.
// An accepted request lands in the input register; its result is loaded into
// the output register, raising tvalid, once it is empty or its result is taken.
// Throughput is one beat per cycle while the receiver does not stall, set by
// the single pass from the input register through the constant-multiply
// compares to the history and output registers.
// When the receiver stalls, the output register holds its result and the input
// register can still take one more request; only then does s_axis_tready fall.
// Reset empties both registers, clears all histories and sets the thresholds
// to 27 and 300.
module ecg_rr_beat_rhythm_classifier_top #(
    parameter int POS_BITS = ecgrr_pkg::POS_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // beat_position [31:0], beat_width [41:32], zero fill
    input  logic [ecgrr_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // restart
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // beat_class [1:0], rhythm_level [5:2], zero fill
    output logic [ecgrr_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // classified
    output logic                                m_axis_tuser,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ecgrr_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import ecgrr_pkg::*;

    localparam int SUM_W = POS_BITS + 2;

    logic                   in_valid_reg;
    logic [POS_BITS-1:0]    in_pos_reg;
    logic [WIDTH_W-1:0]     in_width_reg;
    logic                   in_restart_reg;

    logic [POS_BITS-1:0]    pos_hist_reg [5];
    logic [POS_BITS-1:0]    pos_hist_next [5];
    logic [POS_BITS-1:0]    nrr_reg [4];
    logic [POS_BITS-1:0]    nrr_next [4];
    logic [POS_BITS-1:0]    avg_reg;
    logic [POS_BITS-1:0]    avg_next;
    cls_t                   types_reg [5];
    cls_t                   types_next [5];
    logic [3:0]             sticky_reg;
    logic [3:0]             sticky_next;
    cls_t                   last_reg;
    cls_t                   last_next;

    logic [WIDTH_W-1:0]     wide_thr_reg;
    logic [PAUSE_W-1:0]     pause_thr_reg;

    logic                   out_valid_reg;
    cls_t                   out_class_reg;
    cls_t                   out_class_next;
    logic [3:0]             out_level_reg;
    logic [3:0]             out_level_next;
    logic                   out_classified_reg;
    logic                   out_classified_next;

    logic                   adv;
    logic                   step;
    logic                   cfg_wr;
    logic                   reg_sel;

    logic [POS_BITS-1:0]    pos_eff [5];
    logic [POS_BITS-1:0]    nrr_eff [4];
    logic [POS_BITS-1:0]    avg_eff;
    cls_t                   types_eff [5];
    logic [3:0]             sticky_eff;

    logic [POS_BITS-1:0]    rr [5];
    ivl_status_t            ivl;
    cls_t                   beat_t;
    logic [3:0]             flag;
    logic                   nrr_upd;

    // pipeline handshake
    assign adv           = ~out_valid_reg | m_axis_tready;
    assign step          = in_valid_reg & adv;
    assign s_axis_tready = ~in_valid_reg | adv;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_level_reg, out_class_reg};
    assign m_axis_tuser  = out_classified_reg;

    // configuration
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign reg_sel = paddr[2];
    assign prdata  = (reg_sel == 1'(REG_PAUSE)) ? 32'(pause_thr_reg) : 32'(wide_thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_thr_reg  <= WIDE_QRS_RST;
            pause_thr_reg <= PAUSE_RST;
        end
        else if (cfg_wr)
        begin
            if (reg_sel == 1'(REG_WIDE_QRS))
                wide_thr_reg <= pwdata[WIDTH_W-1:0];
            else
                pause_thr_reg <= pwdata[PAUSE_W-1:0];
        end
    end

    // restart view of the history
    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            pos_eff[i]   = in_restart_reg ? '0 : pos_hist_reg[i];
            types_eff[i] = in_restart_reg ? CLS_N : types_reg[i];
        end
        for (int i = 0; i < 4; i++)
        begin
            nrr_eff[i] = in_restart_reg ? '0 : nrr_reg[i];
        end
        avg_eff    = in_restart_reg ? '0 : avg_reg;
        sticky_eff = in_restart_reg ? LVL_NORMAL : sticky_reg;
    end

    ecgrr_interval #(
        .POS_BITS (POS_BITS)
    ) u_interval (
        .pos_new   (in_pos_reg),
        .pos_old   (pos_eff),
        .avg       (avg_eff),
        .pause_thr (pause_thr_reg),
        .rr        (rr),
        .status    (ivl)
    );

    always_comb
    begin
        if (!ivl.premature)
            beat_t = CLS_N;
        else if (in_width_reg >= wide_thr_reg)
            beat_t = CLS_V;
        else
            beat_t = CLS_A;
    end

    ecgrr_rhythm u_rhythm (
        .t     (beat_t),
        .hist  (types_eff),
        .pause (ivl.pause),
        .flag  (flag)
    );

    assign nrr_upd = (beat_t == CLS_N) && (types_eff[0] == CLS_N) && ivl.in_win;

    always_comb
    begin
        logic [SUM_W-1:0] sum;

        for (int i = 0; i < 4; i++)
        begin
            pos_hist_next[i] = pos_eff[i+1];
        end
        pos_hist_next[4] = in_pos_reg;
        for (int i = 4; i > 0; i--)
        begin
            types_next[i] = types_eff[i-1];
        end

        if (!ivl.all_valid)
        begin
            // warm-up: load the four newest intervals
            for (int i = 0; i < 4; i++)
            begin
                nrr_next[i] = rr[i+1];
            end
            types_next[0]       = last_reg;
            sticky_next         = LVL_NORMAL;
            last_next           = CLS_N;
            out_class_next      = CLS_N;
            out_level_next      = LVL_NORMAL;
            out_classified_next = 1'b0;
        end
        else
        begin
            if (nrr_upd)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nrr_next[i] = nrr_eff[i+1];
                end
                nrr_next[3] = rr[4];
            end
            else
            begin
                for (int i = 0; i < 4; i++)
                begin
                    nrr_next[i] = nrr_eff[i];
                end
            end
            types_next[0]       = beat_t;
            sticky_next         = (flag > sticky_eff) ? flag : sticky_eff;
            last_next           = beat_t;
            out_class_next      = beat_t;
            out_level_next      = sticky_next;
            out_classified_next = 1'b1;
        end

        sum = SUM_W'(nrr_next[0]) + SUM_W'(nrr_next[1])
            + SUM_W'(nrr_next[2]) + SUM_W'(nrr_next[3]);
        if (!ivl.all_valid || nrr_upd)
            avg_next = sum[SUM_W-1:2];
        else
            avg_next = avg_eff;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (adv)
                out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_pos_reg     <= POS_BITS'(s_axis_tdata[POS_IN_W-1:0]);
            in_width_reg   <= s_axis_tdata[POS_IN_W +: WIDTH_W];
            in_restart_reg <= s_axis_tuser;
        end
        if (step)
        begin
            out_class_reg      <= out_class_next;
            out_level_reg      <= out_level_next;
            out_classified_reg <= out_classified_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                pos_hist_reg[i] <= '0;
                types_reg[i]    <= CLS_N;
            end
            for (int i = 0; i < 4; i++)
            begin
                nrr_reg[i] <= '0;
            end
            avg_reg    <= '0;
            sticky_reg <= LVL_NORMAL;
            last_reg   <= CLS_N;
        end
        else if (step)
        begin
            pos_hist_reg <= pos_hist_next;
            types_reg    <= types_next;
            nrr_reg      <= nrr_next;
            avg_reg      <= avg_next;
            sticky_reg   <= sticky_next;
            last_reg     <= last_next;
        end
    end

    a_warmup_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[5:0] == 6'd0))
        else $error("unclassified result carries a class or level");

    a_vent_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser && m_axis_tdata[1:0] == CLS_V)
        |-> (m_axis_tdata[5:2] >= LVL_PVC))
        else $error("ventricular beat with level below pvc");

    a_atrial_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser && m_axis_tdata[1:0] == CLS_A)
        |-> (m_axis_tdata[5:2] >= LVL_APC))
        else $error("atrial beat with level below apc");

    a_sticky_rises: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ivl.all_valid && !in_restart_reg) |=> (sticky_reg >= $past(sticky_reg)))
        else $error("sticky rhythm level fell on a classified beat");

endmodule
